### hw/rtl/aos_pkg.sv
// ----------------------------------------------------------------------------
// aos_pkg
// Shared types and constants of the amplitude outcome sampler: field widths,
// function and status codes, and the command and status structs between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package aos_pkg;

    // Fixed field widths
    localparam int INDEX_W   = 4;
    localparam int OBS_W     = 30;
    localparam int TOL_W     = 30;
    localparam int STATUS_W  = 2;
    localparam int OUTCOME_W = 4;
    localparam int TOTAL_W   = 36;

    // Result tdata: status, outcome, total, padded to whole bytes
    localparam int OUT_RAW_W = STATUS_W + OUTCOME_W + TOTAL_W;
    localparam int OUT_W     = ((OUT_RAW_W + 7) / 8) * 8;

    // One in Q2.30
    localparam logic [31:0] ONE_Q30 = 32'h4000_0000;

    // Tolerance after reset, about 1e-6 of one
    localparam logic [TOL_W-1:0] TOL_RESET = 30'd1074;

    // Function codes carried on tuser
    localparam logic FUNC_LOAD    = 1'b0;
    localparam logic FUNC_MEASURE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK         = 2'd0,
        STATUS_NOT_NORM   = 2'd1,
        STATUS_NO_OUTCOME = 2'd2
    } status_t;

    // Controller to datapath
    typedef struct packed {
        logic    start;          // item accepted: capture, write entry, clear sum
        logic    rd_en;          // issue one table read
        logic    flush;          // drop items still in the read pipeline
        logic    calc_dev;       // form |sum - one|
        logic    capture_hit;    // hold the index of the hit
        logic    out_load;       // load the result register
        status_t out_status;
        logic    out_outcome_en;
        logic    out_total_en;
    } aos_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic item_func;
        logic item_last;
        logic item_in_range;
        logic issue_last;        // read address is the last counted entry
        logic acc_valid;         // running sum took an entry this cycle
        logic acc_last;          // that entry was the last one
        logic hit;               // observation below running sum
        logic dev_ok;            // deviation within tolerance
        logic out_free;          // result register can take a new item
    } aos_stat_t;

endpackage

### hw/rtl/aos_datapath.sv
// ----------------------------------------------------------------------------
// aos_datapath
// Amplitude table, read and square pipeline, running probability sum,
// tolerance check, tolerance register and the result register.
// ----------------------------------------------------------------------------
module aos_datapath #(
    parameter int MAX_STATES = 16,
    parameter int AMP_BITS   = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    input  logic [aos_pkg::TOL_W-1:0]        cfg_data,
    input  logic                             in_func,
    input  logic [aos_pkg::INDEX_W-1:0]      in_entry_index,
    input  logic signed [AMP_BITS-1:0]       in_amp_real,
    input  logic signed [AMP_BITS-1:0]       in_amp_imag,
    input  logic                             in_last,
    input  logic [aos_pkg::OBS_W-1:0]        in_observation,
    input  aos_pkg::aos_cmd_t                cmd,
    output aos_pkg::aos_stat_t               stat,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [aos_pkg::STATUS_W-1:0]     out_status,
    output logic [aos_pkg::OUTCOME_W-1:0]    out_outcome,
    output logic [aos_pkg::TOTAL_W-1:0]      out_total
);
    import aos_pkg::*;

    localparam int ADDR_W  = $clog2(MAX_STATES);
    localparam int CNT_W   = $clog2(MAX_STATES + 1);
    localparam int SQ_W    = 2 * AMP_BITS;
    localparam int SUM_RAW = SQ_W + 1 + ADDR_W;
    localparam int SUM_W   = (SUM_RAW > 32) ? SUM_RAW : 32;
    localparam logic [SUM_W-1:0] ONE_EXT = SUM_W'(ONE_Q30);

    // Amplitude table, imaginary part in the upper half
    logic [SQ_W-1:0]        mem [MAX_STATES];

    logic                   in_range;
    logic                   wr_en;
    logic [ADDR_W-1:0]      wr_addr;

    // Control registers
    logic [CNT_W-1:0]       count_reg;
    logic [ADDR_W-1:0]      rd_addr_reg;
    logic                   item_func_reg;
    logic                   item_last_reg;
    logic                   item_range_reg;
    logic                   rd_valid_reg;
    logic                   sq_valid_reg;
    logic                   acc_valid_reg;
    logic                   out_valid_reg;
    logic [TOL_W-1:0]       tol_reg;

    // Payload registers
    logic [SQ_W-1:0]        rdata_reg;
    logic                   rd_last_reg;
    logic [ADDR_W-1:0]      rd_idx_reg;
    logic [SQ_W-1:0]        sq_re_reg;
    logic [SQ_W-1:0]        sq_im_reg;
    logic                   sq_last_reg;
    logic [ADDR_W-1:0]      sq_idx_reg;
    logic [SUM_W-1:0]       cum_reg;
    logic                   acc_last_reg;
    logic [ADDR_W-1:0]      acc_idx_reg;
    logic [OBS_W-1:0]       obs_reg;
    logic [ADDR_W-1:0]      hit_idx_reg;
    logic [SUM_W-1:0]       dev_reg;
    logic [STATUS_W-1:0]    out_status_reg;
    logic [OUTCOME_W-1:0]   out_outcome_reg;
    logic [TOTAL_W-1:0]     out_total_reg;

    logic signed [AMP_BITS-1:0] rd_re;
    logic signed [AMP_BITS-1:0] rd_im;
    logic signed [SQ_W-1:0]     prod_re;
    logic signed [SQ_W-1:0]     prod_im;
    logic                       issue_last;

    // Entry write on an accepted load inside the table
    assign in_range = int'(in_entry_index) < MAX_STATES;
    assign wr_en    = cmd.start && (in_func == FUNC_LOAD) && in_range;
    assign wr_addr  = ADDR_W'(in_entry_index);

    assign issue_last = (CNT_W'(rd_addr_reg) + CNT_W'(1)) == count_reg;

    // Squares of the stored parts
    assign rd_re   = $signed(rdata_reg[AMP_BITS-1:0]);
    assign rd_im   = $signed(rdata_reg[SQ_W-1:AMP_BITS]);
    assign prod_re = rd_re * rd_re;
    assign prod_im = rd_im * rd_im;

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            rd_addr_reg    <= '0;
            item_func_reg  <= 1'b0;
            item_last_reg  <= 1'b0;
            item_range_reg <= 1'b0;
            rd_valid_reg   <= 1'b0;
            sq_valid_reg   <= 1'b0;
            acc_valid_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
            tol_reg        <= TOL_RESET;
        end
        else
        begin
            if (cfg_valid)
            begin
                tol_reg <= cfg_data;
            end

            if (cmd.start)
            begin
                item_func_reg  <= in_func;
                item_last_reg  <= in_last;
                item_range_reg <= in_range;
                rd_addr_reg    <= '0;
                if (wr_en && in_last)
                begin
                    count_reg <= CNT_W'(in_entry_index) + CNT_W'(1);
                end
            end
            else if (cmd.rd_en)
            begin
                rd_addr_reg <= rd_addr_reg + ADDR_W'(1);
            end

            rd_valid_reg  <= cmd.rd_en && !cmd.flush;
            sq_valid_reg  <= rd_valid_reg && !cmd.flush;
            acc_valid_reg <= sq_valid_reg && !cmd.flush;

            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Table write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= {in_amp_imag, in_amp_real};
        end
        if (cmd.rd_en)
        begin
            rdata_reg <= mem[rd_addr_reg];
        end
    end

    // Read, square and sum pipeline, result payload
    always_ff @(posedge clk)
    begin
        rd_last_reg <= issue_last;
        rd_idx_reg  <= rd_addr_reg;

        sq_re_reg   <= $unsigned(prod_re);
        sq_im_reg   <= $unsigned(prod_im);
        sq_last_reg <= rd_last_reg;
        sq_idx_reg  <= rd_idx_reg;

        acc_last_reg <= sq_last_reg;
        acc_idx_reg  <= sq_idx_reg;

        if (cmd.start)
        begin
            cum_reg <= '0;
            obs_reg <= in_observation;
        end
        else if (sq_valid_reg && !cmd.flush)
        begin
            cum_reg <= cum_reg + SUM_W'(sq_re_reg) + SUM_W'(sq_im_reg);
        end

        if (cmd.capture_hit)
        begin
            hit_idx_reg <= acc_idx_reg;
        end

        if (cmd.calc_dev)
        begin
            dev_reg <= (cum_reg > ONE_EXT) ? cum_reg - ONE_EXT : ONE_EXT - cum_reg;
        end

        if (cmd.out_load)
        begin
            out_status_reg  <= cmd.out_status;
            out_outcome_reg <= cmd.out_outcome_en ? OUTCOME_W'(hit_idx_reg) : '0;
            out_total_reg   <= cmd.out_total_en ? TOTAL_W'(cum_reg) : '0;
        end
    end

    // Status towards the controller
    always_comb
    begin
        stat.item_func     = item_func_reg;
        stat.item_last     = item_last_reg;
        stat.item_in_range = item_range_reg;
        stat.issue_last    = issue_last;
        stat.acc_valid     = acc_valid_reg;
        stat.acc_last      = acc_last_reg;
        stat.hit           = acc_valid_reg && (SUM_W'(obs_reg) < cum_reg);
        stat.dev_ok        = dev_reg <= SUM_W'(tol_reg);
        stat.out_free      = !out_valid_reg || out_ready;
    end

    assign out_valid   = out_valid_reg;
    assign out_status  = out_status_reg;
    assign out_outcome = out_outcome_reg;
    assign out_total   = out_total_reg;

endmodule

### hw/rtl/aos_ctrl.sv
// ----------------------------------------------------------------------------
// aos_ctrl
// Sequencer of the sampler: decodes each item, drives the table walk, decides
// the result status and keeps the normalized mark.
// ----------------------------------------------------------------------------
module aos_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output aos_pkg::aos_cmd_t   cmd,
    input  aos_pkg::aos_stat_t  stat
);
    import aos_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_WALK,
        S_DRAIN,
        S_DEV,
        S_CHECK,
        S_FIN
    } state_t;

    state_t  state_reg, state_next;
    logic    mark_reg, mark_next;
    status_t res_status_reg, res_status_next;
    logic    res_outcome_en_reg, res_outcome_en_next;
    logic    res_total_en_reg, res_total_en_next;
    logic    walking;
    logic    measure_hit;

    assign walking     = (state_reg == S_WALK) || (state_reg == S_DRAIN);
    assign measure_hit = walking && stat.acc_valid && stat.hit
                         && (stat.item_func == FUNC_MEASURE);

    // Next state and result decision
    always_comb
    begin
        state_next          = state_reg;
        mark_next           = mark_reg;
        res_status_next     = res_status_reg;
        res_outcome_en_next = res_outcome_en_reg;
        res_total_en_next   = res_total_en_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                res_status_next     = STATUS_OK;
                res_outcome_en_next = 1'b0;
                res_total_en_next   = 1'b0;
                if (stat.item_func == FUNC_LOAD)
                begin
                    state_next = (stat.item_in_range && stat.item_last) ? S_WALK : S_FIN;
                end
                else if (!mark_reg)
                begin
                    res_status_next = STATUS_NOT_NORM;
                    state_next      = S_FIN;
                end
                else
                begin
                    state_next = S_WALK;
                end
            end
            S_WALK, S_DRAIN:
            begin
                if (state_reg == S_WALK && stat.issue_last)
                begin
                    state_next = S_DRAIN;
                end
                if (measure_hit)
                begin
                    res_status_next     = STATUS_OK;
                    res_outcome_en_next = 1'b1;
                    state_next          = S_FIN;
                end
                else if (stat.acc_valid && stat.acc_last)
                begin
                    if (stat.item_func == FUNC_MEASURE)
                    begin
                        res_status_next = STATUS_NO_OUTCOME;
                        state_next      = S_FIN;
                    end
                    else
                    begin
                        state_next = S_DEV;
                    end
                end
            end
            S_DEV:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                mark_next         = stat.dev_ok;
                res_status_next   = stat.dev_ok ? STATUS_OK : STATUS_NOT_NORM;
                res_total_en_next = 1'b1;
                state_next        = S_FIN;
            end
            S_FIN:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            mark_reg           <= 1'b0;
            res_status_reg     <= STATUS_OK;
            res_outcome_en_reg <= 1'b0;
            res_total_en_reg   <= 1'b0;
        end
        else
        begin
            state_reg          <= state_next;
            mark_reg           <= mark_next;
            res_status_reg     <= res_status_next;
            res_outcome_en_reg <= res_outcome_en_next;
            res_total_en_reg   <= res_total_en_next;
        end
    end

    // Commands
    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd.start          = (state_reg == S_IDLE) && in_valid;
        cmd.rd_en          = (state_reg == S_WALK);
        cmd.flush          = measure_hit;
        cmd.capture_hit    = measure_hit;
        cmd.calc_dev       = (state_reg == S_DEV);
        cmd.out_load       = (state_reg == S_FIN) && stat.out_free;
        cmd.out_status     = res_status_reg;
        cmd.out_outcome_en = res_outcome_en_reg;
        cmd.out_total_en   = res_total_en_reg;
    end

    // Checks
    a_mark_only_from_check: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(mark_reg) |-> $past(state_reg) == S_CHECK)
        else $error("normalized mark set outside the tolerance check");

    a_pipe_empty_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !stat.acc_valid)
        else $error("sum pipeline still busy while idle");

    a_not_norm_short: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DECODE && stat.item_func == FUNC_MEASURE && !mark_reg)
        |=> (state_reg == S_FIN && res_status_reg == STATUS_NOT_NORM))
        else $error("measure without normalized table did not report at once");

    a_hit_reported: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture_hit |=> (state_reg == S_FIN && res_outcome_en_reg))
        else $error("hit not carried to the result");

endmodule

### hw/rtl/amplitude_outcome_sampler_core.sv
// ----------------------------------------------------------------------------
// amplitude_outcome_sampler_core
// Complex amplitude table with inverse-CDF outcome sampling.
// ----------------------------------------------------------------------------
// One item is handled at a time, and a result is always produced per item.
// A non-final load, a load outside the table and a measure on a table that is
// not normalized go from decode straight to the result stage, with no walk.
// A final load of entry N walks entries 0..N through the single table read
// port, one entry a cycle, then squares, sums and checks the tolerance. A
// measure walks the same way and stops at the first entry whose running sum
// exceeds the observation, or reports no outcome after entry N. A new item is
// taken as soon as the result is in the output register, even if it has not
// been taken yet. The tolerance register is to be written through the cfg
// channel only while idle; the user must keep to this, the block itself does
// not enforce it.
// ----------------------------------------------------------------------------
module amplitude_outcome_sampler_core #(
    parameter int  MAX_STATES = 16,
    parameter int  AMP_BITS   = 16,
    localparam int IN_RAW_W   = aos_pkg::INDEX_W + 2 * AMP_BITS + aos_pkg::OBS_W,
    localparam int IN_W       = ((IN_RAW_W + 7) / 8) * 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // Tolerance register
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [aos_pkg::TOL_W-1:0]   cfg_data,
    // Input items
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [IN_W-1:0]             s_tdata,   // entry_index, amp_real, amp_imag,
                                                   // observation, zero pad
    input  logic                        s_tlast,   // last_entry
    input  logic                        s_tuser,   // func
    // Result items
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [aos_pkg::OUT_W-1:0]   m_tdata    // status, outcome, prob_sum,
                                                   // zero pad
);
    import aos_pkg::*;

    aos_cmd_t                   cmd;
    aos_stat_t                  stat;
    logic [INDEX_W-1:0]         entry_index;
    logic signed [AMP_BITS-1:0] amp_real;
    logic signed [AMP_BITS-1:0] amp_imag;
    logic [OBS_W-1:0]           observation;
    logic [STATUS_W-1:0]        res_status;
    logic [OUTCOME_W-1:0]       res_outcome;
    logic [TOTAL_W-1:0]         res_total;

    // Unpack the input item
    assign entry_index = s_tdata[INDEX_W-1:0];
    assign amp_real    = $signed(s_tdata[INDEX_W +: AMP_BITS]);
    assign amp_imag    = $signed(s_tdata[INDEX_W + AMP_BITS +: AMP_BITS]);
    assign observation = s_tdata[INDEX_W + 2 * AMP_BITS +: OBS_W];

    assign cfg_ready = 1'b1;

    aos_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    aos_datapath #(
        .MAX_STATES (MAX_STATES),
        .AMP_BITS   (AMP_BITS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_data       (cfg_data),
        .in_func        (s_tuser),
        .in_entry_index (entry_index),
        .in_amp_real    (amp_real),
        .in_amp_imag    (amp_imag),
        .in_last        (s_tlast),
        .in_observation (observation),
        .cmd            (cmd),
        .stat           (stat),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .out_status     (res_status),
        .out_outcome    (res_outcome),
        .out_total      (res_total)
    );

    // Pack the result item
    assign m_tdata = {{(OUT_W - OUT_RAW_W){1'b0}}, res_total, res_outcome, res_status};

endmodule
